[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk_i, ignored while rst_ni is low.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property sampled on clk_i in every cycle, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/hvac_ufr_pkg.sv]
// ----------------------------------------------------------------------------
// hvac_ufr_pkg
// Types, status codes and protocol constants of the UART frame receiver.
// ----------------------------------------------------------------------------
package hvac_ufr_pkg;

  localparam int TimerWidthDef = 16;
  localparam int TimeoutWidth  = 16;

  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd200;

  // item kinds
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // frame_status codes
  localparam logic [3:0] StInProgress = 4'd0;
  localparam logic [3:0] StBadHeader  = 4'd1;
  localparam logic [3:0] StBadSum     = 4'd2;
  localparam logic [3:0] StValue      = 4'd3;
  localparam logic [3:0] StAck        = 4'd4;
  localparam logic [3:0] StOther      = 4'd5;
  localparam logic [3:0] StTimeout    = 4'd6;
  localparam logic [3:0] StIdleTick   = 4'd7;
  localparam logic [3:0] StBadLength  = 4'd8;

  localparam logic [7:0] HdrStart   = 8'h02;
  localparam logic [7:0] HdrChecked = 8'h03;
  localparam logic [7:0] MaxCount   = 8'd248;
  localparam logic [7:0] CountPos   = 8'd6;
  localparam logic [7:0] CapFirst   = 8'd12;
  localparam logic [7:0] CapLast    = 8'd15;
  localparam logic [8:0] FrameOvh   = 9'd7;
  localparam logic [8:0] LenValueA  = 9'd15;
  localparam logic [8:0] LenAck     = 9'd16;
  localparam logic [8:0] LenValueB  = 9'd17;
  localparam logic [7:0] LenBadHdr  = 8'd1;
  localparam logic [7:0] LenBadCnt  = 8'd7;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] cmd;
    logic [7:0] value;
    logic [7:0] len;
  } res_t;

endpackage

[src/hvac_ufr_pipe.sv]
// ----------------------------------------------------------------------------
// hvac_ufr_pipe
// One valid/ready register stage; takes a new beat whenever it is empty or
// its beat leaves in the same cycle.
// ----------------------------------------------------------------------------
module hvac_ufr_pipe #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

[src/hvac_ufr_core.sv]
// ----------------------------------------------------------------------------
// hvac_ufr_core
// Frame tracker: position, running checksum, payload count, captured bytes
// and idle timer; decodes one beat per cycle into one result when res_ready_i.
// ----------------------------------------------------------------------------
module hvac_ufr_core #(
  parameter int TIMER_WIDTH = hvac_ufr_pkg::TimerWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [hvac_ufr_pkg::TimeoutWidth-1:0] cfg_data_i,
  input  logic                                 item_valid_i,
  output logic                                 item_ready_o,
  input  hvac_ufr_pkg::item_t                  item_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output hvac_ufr_pkg::res_t                   res_o
);

  localparam int CmpW = (TIMER_WIDTH > hvac_ufr_pkg::TimeoutWidth) ?
                        TIMER_WIDTH : hvac_ufr_pkg::TimeoutWidth;

  logic [hvac_ufr_pkg::TimeoutWidth-1:0] tmo_q, tmo_d;
  logic [TIMER_WIDTH-1:0] idle_q, idle_d, idle_inc;
  logic [7:0] pos_q, pos_d, pos_inc;
  logic       active_q, active_d;
  logic       unchk_q, unchk_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] cnt_q, cnt_d, cnt_eff;
  logic [3:0][7:0] cap_q, cap_d;
  logic [8:0] last, len9;
  logic       fire;
  logic [7:0] b;
  hvac_ufr_pkg::res_t res;

  assign item_ready_o = res_ready_i;
  assign fire         = item_valid_i && res_ready_i;
  assign res_valid_o  = item_valid_i;
  assign res_o        = res;
  assign b            = item_i.data;

  assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign pos_inc  = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
  assign cnt_eff  = (pos_q == hvac_ufr_pkg::CountPos) ? b : cnt_q;
  assign last     = {1'b0, cnt_eff} + hvac_ufr_pkg::FrameOvh;
  assign len9     = {1'b0, pos_q} + 9'd1;

  always_comb begin
    tmo_d    = cfg_valid_i ? cfg_data_i : tmo_q;
    idle_d   = idle_q;
    pos_d    = pos_q;
    active_d = active_q;
    unchk_d  = unchk_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    cap_d    = cap_q;
    res      = '0;
    res.status = hvac_ufr_pkg::StInProgress;

    if (fire) begin
      if (item_i.op == hvac_ufr_pkg::OpTick) begin
        idle_d = idle_inc;
        if (active_q && (CmpW'(idle_inc) > CmpW'(tmo_q))) begin
          res.status = hvac_ufr_pkg::StTimeout;
          res.len    = pos_q;
          pos_d      = '0;
          active_d   = 1'b0;
          unchk_d    = 1'b0;
          sum_d      = '0;
          cnt_d      = '0;
          cap_d      = '0;
        end else begin
          res.status = hvac_ufr_pkg::StIdleTick;
        end
      end else if (!active_q) begin
        if (b != hvac_ufr_pkg::HdrStart) begin
          res.status = hvac_ufr_pkg::StBadHeader;
          res.len    = hvac_ufr_pkg::LenBadHdr;
        end else begin
          // open a frame; the start byte stays out of the checksum
          active_d = 1'b1;
          unchk_d  = 1'b0;
          pos_d    = 8'd1;
          sum_d    = '0;
          cnt_d    = '0;
          cap_d    = '0;
          idle_d   = '0;
        end
      end else if (unchk_q || pos_q < 8'd2) begin
        sum_d  = sum_q + b;
        pos_d  = pos_inc;
        idle_d = '0;
      end else if (pos_q == 8'd2 && b != hvac_ufr_pkg::HdrChecked) begin
        // no length field: collect until the timer drops it
        unchk_d = 1'b1;
        pos_d   = pos_inc;
        idle_d  = '0;
      end else if (pos_q == hvac_ufr_pkg::CountPos && b > hvac_ufr_pkg::MaxCount) begin
        res.status = hvac_ufr_pkg::StBadLength;
        res.len    = hvac_ufr_pkg::LenBadCnt;
        pos_d      = '0;
        active_d   = 1'b0;
        unchk_d    = 1'b0;
        sum_d      = '0;
        cnt_d      = '0;
        cap_d      = '0;
      end else if (pos_q < 8'd7 || {1'b0, pos_q} < last) begin
        cnt_d  = cnt_eff;
        sum_d  = sum_q + b;
        pos_d  = pos_inc;
        idle_d = '0;
        if (pos_q >= hvac_ufr_pkg::CapFirst && pos_q <= hvac_ufr_pkg::CapLast) begin
          cap_d[pos_q[1:0]] = b;
        end
      end else begin
        // closing checksum byte
        res.len = len9[8] ? 8'hFF : len9[7:0];
        if (b != (8'd0 - sum_q)) begin
          res.status = hvac_ufr_pkg::StBadSum;
        end else if (len9 == hvac_ufr_pkg::LenValueA) begin
          res.status = hvac_ufr_pkg::StValue;
          res.cmd    = cap_q[0];
          res.value  = cap_q[1];
        end else if (len9 == hvac_ufr_pkg::LenValueB) begin
          res.status = hvac_ufr_pkg::StValue;
          res.cmd    = cap_q[2];
          res.value  = cap_q[3];
        end else if (len9 == hvac_ufr_pkg::LenAck) begin
          res.status = hvac_ufr_pkg::StAck;
        end else begin
          res.status = hvac_ufr_pkg::StOther;
        end
        pos_d    = '0;
        active_d = 1'b0;
        unchk_d  = 1'b0;
        sum_d    = '0;
        cnt_d    = '0;
        cap_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q    <= hvac_ufr_pkg::TimeoutReset;
      idle_q   <= '0;
      pos_q    <= '0;
      active_q <= 1'b0;
      unchk_q  <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
      cap_q    <= '0;
    end else begin
      tmo_q    <= tmo_d;
      idle_q   <= idle_d;
      pos_q    <= pos_d;
      active_q <= active_d;
      unchk_q  <= unchk_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      cap_q    <= cap_d;
    end
  end

endmodule

[src/hvac_uart_frame_receiver.sv]
// ----------------------------------------------------------------------------
// hvac_uart_frame_receiver
// Checks received UART frames byte by byte and reports one result per beat.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready  | operation, byte_value
//   out     | output    | out_valid / out_ready| frame_status, command_code,
//           |           |                      | value_byte, frame_length
//   cfg     | input     | cfg_valid / cfg_ready| timeout_ticks
//
// One beat per cycle sustained while out is not stalled; each input beat
// passes the input register, then the decode into the result register.
// Reset empties both registers, closes any frame and loads timeout 200.
// A stall on out holds the result register and then the input register;
// the frame state advances only when a decoded beat moves into the result
// register. cfg_ready is always high.
// ----------------------------------------------------------------------------
module hvac_uart_frame_receiver #(
  parameter int TIMER_WIDTH = hvac_ufr_pkg::TimerWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  frame_status_o,
  output logic [7:0]  command_code_o,
  output logic [7:0]  value_byte_o,
  output logic [7:0]  frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] timeout_ticks_i
);

  hvac_ufr_pkg::item_t in_item, st_item;
  hvac_ufr_pkg::res_t  core_res, out_res;
  logic st_valid, st_ready;
  logic core_valid, core_ready;

  assign in_item.op   = operation_i;
  assign in_item.data = byte_value_i;
  assign cfg_ready_o  = 1'b1;

  hvac_ufr_pipe #(
    .Width($bits(hvac_ufr_pkg::item_t))
  ) u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .data_i (in_item),
    .valid_o(st_valid),
    .ready_i(st_ready),
    .data_o (st_item)
  );

  hvac_ufr_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (timeout_ticks_i),
    .item_valid_i(st_valid),
    .item_ready_o(st_ready),
    .item_i      (st_item),
    .res_valid_o (core_valid),
    .res_ready_i (core_ready),
    .res_o       (core_res)
  );

  hvac_ufr_pipe #(
    .Width($bits(hvac_ufr_pkg::res_t))
  ) u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(core_valid),
    .ready_o(core_ready),
    .data_i (core_res),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_res)
  );

  assign frame_status_o = out_res.status;
  assign command_code_o = out_res.cmd;
  assign value_byte_o   = out_res.value;
  assign frame_length_o = out_res.len;

endmodule

[src/hvac_ufr_checker.sv]
// ----------------------------------------------------------------------------
// hvac_ufr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hvac_ufr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] frame_status_o,
  input logic [7:0] command_code_o,
  input logic [7:0] value_byte_o,
  input logic [7:0] frame_length_o
);

  // hold a stalled result beat
  `ASSERT_CLKD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_status_o) && $stable(frame_length_o) && $stable(command_code_o) && $stable(value_byte_o), "result beat changed while stalled")

  `ASSERT_CLK(a_cmd_only_value, out_valid_o && frame_status_o != hvac_ufr_pkg::StValue |-> command_code_o == 8'd0 && value_byte_o == 8'd0, "command or value on a non-value result")

  `ASSERT_CLK(a_value_len, out_valid_o && frame_status_o == hvac_ufr_pkg::StValue |-> frame_length_o == 8'd15 || frame_length_o == 8'd17, "value frame with wrong length")

  `ASSERT_CLK(a_fixed_len, out_valid_o && (frame_status_o == hvac_ufr_pkg::StInProgress || frame_status_o == hvac_ufr_pkg::StIdleTick) |-> frame_length_o == 8'd0, "length reported without a finished frame")

endmodule

bind hvac_uart_frame_receiver hvac_ufr_checker u_ufr_checker (.*);
